[rtl/core/rtpds_pkg.sv]
// Shared types and constants for the RTP DTMF packet sequencer.
`timescale 1ns / 1ps

package rtpds_pkg;

   // Request operation carried in req_tuser
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_PUSH    = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   // Response kind carried in rsp_tuser
   typedef enum logic [1:0] {
      KIND_AUDIO  = 2'd0,
      KIND_EVENT  = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_KNOWN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SOURCE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_PT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SEQUENCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_TSTAMP   = 3'd4;

   localparam int CSR_DATA_W = 32;

   // Field widths
   localparam int PT_W    = 7;
   localparam int SEQ_W   = 16;
   localparam int TS_W    = 32;
   localparam int EV_W    = 8;
   localparam int VOL_W   = 6;
   localparam int DUR_W   = 11;
   localparam int PD_W    = 4;   // packets-per-digit count, up to 15
   localparam int DUR_P_W = 15;  // unsaturated duration product

   localparam logic [PT_W-1:0]  PT_RESET     = 7'd101;
   localparam logic [PT_W-1:0]  PT_PCMU      = 7'd0;
   localparam logic [VOL_W-1:0] EVENT_VOLUME = 6'd10;
   localparam logic [DUR_W-1:0] DURATION_MAX = 11'd2047;

   localparam int IN_TDATA_W  = 8;
   localparam int OUT_TDATA_W = 88;

   // Result fields as delivered on the response channel
   typedef struct packed {
      kind_type          kind;
      logic              marker;
      logic [PT_W-1:0]   payload_type;
      logic [SEQ_W-1:0]  sequence_number;
      logic [TS_W-1:0]   timestamp;
      logic [EV_W-1:0]   dtmf_event;
      logic              end_flag;
      logic [VOL_W-1:0]  volume;
      logic [DUR_W-1:0]  duration;
   } rsp_type;

   // Decision stage: event code still to come from the queue memory
   typedef struct packed {
      kind_type          kind;
      logic              marker;
      logic [PT_W-1:0]   payload_type;
      logic [SEQ_W-1:0]  sequence_number;
      logic [TS_W-1:0]   timestamp;
      logic              end_flag;
      logic [VOL_W-1:0]  volume;
      logic [DUR_W-1:0]  duration;
      logic              new_digit;
   } dec_type;

endpackage

[rtl/core/rtp_dtmf_packet_sequencer.sv]
// Top level: RTP telephone-event packet sequencer with a DTMF digit queue.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+------------------------------------------
// req      | in  | req_tvalid/tready   | tuser: operation; tdata: digit_event
// rsp      | out | rsp_tvalid/tready   | tuser: packet_kind; tdata: packet header
//          |     |                     |   and event payload (see port comment)
// csr      | in  | csr_we              | csr_index, csr_wdata (write only)
//
// One request per cycle, unless a stalled response holds req_tready low. A
// request is decided in the cycle it is accepted; the registered queue memory
// read completes in the decision register, and the response register follows.
// The decision register doubles as a skid stage: one more request is taken
// while a response waits on rsp_tready. Synchronous reset clears control
// state; the queue memory is not cleared, only written entries are ever read.

module rtp_dtmf_packet_sequencer #(
   parameter int FRAME_SAMPLES     = 160,
   parameter int QUEUE_DEPTH       = 16,
   parameter int PACKETS_PER_DIGIT = 8,
   parameter int END_PACKETS       = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_tuser,  // [1:0] operation
   input  logic [rtpds_pkg::IN_TDATA_W-1:0]    req_tdata,  // [7:0] digit_event
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [1:0]                          rsp_tuser,  // [1:0] packet_kind
   // [0] marker, [7:1] payload_type, [23:8] sequence_number,
   // [55:24] timestamp, [63:56] dtmf_event, [64] end_flag,
   // [70:65] volume, [81:71] duration, [87:82] zero
   output logic [rtpds_pkg::OUT_TDATA_W-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [rtpds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtpds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import rtpds_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0]      QDEPTH    = CW'(QUEUE_DEPTH);
   localparam logic [PD_W-1:0]    PPD       = PD_W'(PACKETS_PER_DIGIT);
   localparam logic [PD_W-1:0]    END_START = PD_W'(PACKETS_PER_DIGIT - END_PACKETS);
   localparam logic [DUR_P_W-1:0] FRAME_P   = DUR_P_W'(FRAME_SAMPLES);
   localparam logic [TS_W-1:0]    FRAME_TS  = TS_W'(FRAME_SAMPLES);

   // configuration registers
   logic              peer_known_ff;
   logic [PT_W-1:0]   event_pt_ff;
   logic [SEQ_W-1:0]  init_seq_ff;
   logic [TS_W-1:0]   init_ts_ff;

   // sequencer state
   logic [SEQ_W-1:0]  next_seq_ff,      next_seq_in;
   logic [TS_W-1:0]   next_ts_ff,       next_ts_in;
   logic              audio_started_ff, audio_started_in;
   logic              digit_active_ff,  digit_active_in;
   logic [EV_W-1:0]   current_event_ff, current_event_in;
   logic [PD_W-1:0]   packets_done_ff,  packets_done_in;
   logic [TS_W-1:0]   digit_ts_ff,      digit_ts_in;
   logic [CW-1:0]     rd_idx_ff,        rd_idx_in;
   logic [CW-1:0]     q_len_ff,         q_len_in;

   // decision and response registers
   logic              dec_valid_ff, dec_valid_in;
   dec_type           dec_ff,       dec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,       rsp_in;

   // queue memory ports
   logic              q_we, q_re;
   logic [EV_W-1:0]   q_rdata;

   logic              accept, dec_advance, produce;
   op_type            op;
   logic              start, active;
   logic [PD_W-1:0]   pd, pd_inc;
   logic [TS_W-1:0]   dts;
   logic [CW-1:0]     rd_idx_next;
   logic [DUR_P_W-1:0] dur_full;

   assign op          = op_type'(req_tuser);
   assign dec_advance = dec_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !dec_valid_ff || dec_advance;
   assign accept      = req_tvalid && req_tready;

   // configuration writes; SSRC is accepted but not held here
   always_ff @(posedge clock) begin
      if (reset) begin
         peer_known_ff <= 1'b0;
         event_pt_ff   <= PT_RESET;
         init_seq_ff   <= '0;
         init_ts_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PEER_KNOWN:    peer_known_ff <= csr_wdata[0];
            CSR_SYNC_SOURCE:   ;
            CSR_EVENT_PT:      event_pt_ff   <= csr_wdata[PT_W-1:0];
            CSR_INIT_SEQUENCE: init_seq_ff   <= csr_wdata[SEQ_W-1:0];
            CSR_INIT_TSTAMP:   init_ts_ff    <= csr_wdata[TS_W-1:0];
            default: ;
         endcase
      end
   end

   // per-tick digit bookkeeping
   assign start    = !digit_active_ff && (rd_idx_ff < q_len_ff);
   assign active   = digit_active_ff || start;
   assign pd       = start ? '0 : packets_done_ff;
   assign pd_inc   = pd + 1'b1;
   assign dts      = start ? next_ts_ff : digit_ts_ff;
   assign dur_full = DUR_P_W'(pd_inc) * FRAME_P;
   assign rd_idx_next = start ? rd_idx_ff + 1'b1 : rd_idx_ff;

   // decision: state update and header fields for an accepted request
   always_comb begin
      next_seq_in      = next_seq_ff;
      next_ts_in       = next_ts_ff;
      audio_started_in = audio_started_ff;
      digit_active_in  = digit_active_ff;
      packets_done_in  = packets_done_ff;
      digit_ts_in      = digit_ts_ff;
      rd_idx_in        = rd_idx_ff;
      q_len_in         = q_len_ff;
      q_we             = 1'b0;
      q_re             = 1'b0;
      produce          = 1'b0;
      dec_in           = '0;
      dec_in.kind      = KIND_AUDIO;

      if (accept) begin
         case (op)
            OP_TICK: begin
               if (peer_known_ff) begin
                  produce         = 1'b1;
                  next_seq_in     = next_seq_ff + 1'b1;
                  next_ts_in      = next_ts_ff + FRAME_TS;
                  dec_in.sequence_number = next_seq_ff;
                  if (active) begin
                     q_re                 = start;
                     dec_in.kind          = KIND_EVENT;
                     dec_in.marker        = (pd == '0);
                     dec_in.payload_type  = event_pt_ff;
                     dec_in.timestamp     = dts;
                     dec_in.end_flag      = (pd >= END_START);
                     dec_in.volume        = EVENT_VOLUME;
                     dec_in.duration      = (dur_full > DUR_P_W'(DURATION_MAX))
                                            ? DURATION_MAX : dur_full[DUR_W-1:0];
                     dec_in.new_digit     = start;
                     digit_ts_in          = dts;
                     packets_done_in      = pd_inc;
                     rd_idx_in            = rd_idx_next;
                     digit_active_in      = 1'b1;
                     if (pd_inc >= PPD) begin
                        digit_active_in = 1'b0;
                        // queue drained: rewind it
                        if (rd_idx_next >= q_len_ff) begin
                           q_len_in  = '0;
                           rd_idx_in = '0;
                        end
                     end
                  end else begin
                     dec_in.marker       = !audio_started_ff;
                     dec_in.payload_type = PT_PCMU;
                     dec_in.timestamp    = next_ts_ff;
                     audio_started_in    = 1'b1;
                  end
               end
            end
            OP_PUSH: begin
               if (q_len_ff >= QDEPTH) begin
                  produce     = 1'b1;
                  dec_in.kind = KIND_REJECT;
               end else begin
                  q_we     = 1'b1;
                  q_len_in = q_len_ff + 1'b1;
               end
            end
            OP_RESTART: begin
               next_seq_in      = init_seq_ff;
               next_ts_in       = init_ts_ff;
               q_len_in         = '0;
               rd_idx_in        = '0;
               digit_active_in  = 1'b0;
               packets_done_in  = '0;
               audio_started_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   rtpds_ram #(
      .WIDTH (EV_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (q_len_ff[AW-1:0]),
      .wdata (req_tdata[EV_W-1:0]),
      .re    (q_re),
      .raddr (rd_idx_ff[AW-1:0]),
      .rdata (q_rdata)
   );

   // response: merge in the event code. The memory read data holds until the
   // next read, which only happens once this decision has moved on.
   always_comb begin
      dec_valid_in     = dec_valid_ff;
      rsp_valid_in     = rsp_valid_ff;
      current_event_in = current_event_ff;
      rsp_in           = rsp_ff;
      if (dec_advance) begin
         dec_valid_in = 1'b0;
      end
      if (accept && produce) begin
         dec_valid_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (dec_advance) begin
         rsp_valid_in           = 1'b1;
         rsp_in.kind            = dec_ff.kind;
         rsp_in.marker          = dec_ff.marker;
         rsp_in.payload_type    = dec_ff.payload_type;
         rsp_in.sequence_number = dec_ff.sequence_number;
         rsp_in.timestamp       = dec_ff.timestamp;
         rsp_in.end_flag        = dec_ff.end_flag;
         rsp_in.volume          = dec_ff.volume;
         rsp_in.duration        = dec_ff.duration;
         rsp_in.dtmf_event      = '0;
         if (dec_ff.new_digit) begin
            current_event_in  = q_rdata;
            rsp_in.dtmf_event = q_rdata;
         end else if (dec_ff.kind == KIND_EVENT) begin
            rsp_in.dtmf_event = current_event_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff      <= '0;
         next_ts_ff       <= '0;
         audio_started_ff <= 1'b0;
         digit_active_ff  <= 1'b0;
         current_event_ff <= '0;
         packets_done_ff  <= '0;
         digit_ts_ff      <= '0;
         rd_idx_ff        <= '0;
         q_len_ff         <= '0;
         dec_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         next_seq_ff      <= next_seq_in;
         next_ts_ff       <= next_ts_in;
         audio_started_ff <= audio_started_in;
         digit_active_ff  <= digit_active_in;
         current_event_ff <= current_event_in;
         packets_done_ff  <= packets_done_in;
         digit_ts_ff      <= digit_ts_in;
         rd_idx_ff        <= rd_idx_in;
         q_len_ff         <= q_len_in;
         dec_valid_ff     <= dec_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         dec_ff <= dec_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {6'd0,
                        rsp_ff.duration,
                        rsp_ff.volume,
                        rsp_ff.end_flag,
                        rsp_ff.dtmf_event,
                        rsp_ff.timestamp,
                        rsp_ff.sequence_number,
                        rsp_ff.payload_type,
                        rsp_ff.marker};

endmodule

[rtl/core/rtpds_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module rtpds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[tb/tb_rtp_dtmf_packet_sequencer.sv]
// Self-checking testbench for the RTP DTMF packet sequencer.
`timescale 1ns / 1ps

module tb_rtp_dtmf_packet_sequencer;
   import rtpds_pkg::*;

   // Block parameters, passed to the instance so the packet model tracks them
   localparam int FRAME_SAMPLES     = 160;
   localparam int QUEUE_DEPTH       = 16;
   localparam int PACKETS_PER_DIGIT = 8;
   localparam int END_PACKETS       = 3;

   // The package names three operations; the fourth code is ignored by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Settling margin after the last response, stall length and watchdog limit
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLDOFF_CYCLES = 120;
   localparam int STALL_LIMIT    = 2000;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] digit;
   } request_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [1:0]             req_tuser = '0;
   logic [IN_TDATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [1:0]             rsp_tuser;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rtp_dtmf_packet_sequencer #(
      .FRAME_SAMPLES     (FRAME_SAMPLES),
      .QUEUE_DEPTH       (QUEUE_DEPTH),
      .PACKETS_PER_DIGIT (PACKETS_PER_DIGIT),
      .END_PACKETS       (END_PACKETS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Packet model: register copies and sequencer state
   // ------------------------------------------------------------------
   logic             cfg_peer_known = 1'b0;
   logic [31:0]      cfg_ssrc = '0;          // held only, never in a packet
   logic [PT_W-1:0]  cfg_event_pt = PT_RESET;
   logic [SEQ_W-1:0] cfg_init_seq = '0;
   logic [TS_W-1:0]  cfg_init_ts = '0;

   logic [SEQ_W-1:0] next_seq = '0;
   logic [TS_W-1:0]  next_ts = '0;
   logic             audio_started = 1'b0;
   logic             digit_active = 1'b0;
   logic [EV_W-1:0]  cur_event = '0;
   int               packets_done = 0;
   logic [TS_W-1:0]  digit_ts = '0;
   logic [EV_W-1:0]  digit_store [QUEUE_DEPTH];
   int               rd_idx = 0;
   int               q_len = 0;

   request_item_type pending_requests[$];   // stimulus not yet offered
   rsp_type          expected_packets[$];   // packets predicted, not yet seen

   int  mismatch_count = 0;
   int  requests_queued = 0;   // ignored opcodes not counted
   bit  calm = 1'b0;           // last part of the run: no idling at all
   int  holdoff_requests = 0;  // bumped by the stimulus to ask for a long stall
   int  holdoff_served = 0;

   // Work out what one accepted request produces and advance the model
   task automatic predict_request(input logic [1:0] op, input logic [7:0] digit);
      rsp_type pkt;
      int      dur_samples;
      pkt = '0;
      case (op)
         OP_TICK: begin
            if (cfg_peer_known) begin
               // Start the next queued digit if nothing is in flight
               if (!digit_active && rd_idx < q_len && rd_idx < QUEUE_DEPTH) begin
                  cur_event = digit_store[rd_idx];
                  rd_idx++;
                  digit_active = 1'b1;
                  packets_done = 0;
                  digit_ts = next_ts;
               end
               pkt.sequence_number = next_seq;
               if (digit_active) begin
                  dur_samples = (packets_done + 1) * FRAME_SAMPLES;
                  if (dur_samples > DURATION_MAX) dur_samples = DURATION_MAX;
                  pkt.kind = KIND_EVENT;
                  pkt.marker = (packets_done == 0);
                  pkt.payload_type = cfg_event_pt;
                  pkt.timestamp = digit_ts;
                  pkt.dtmf_event = cur_event;
                  pkt.end_flag = (packets_done >= PACKETS_PER_DIGIT - END_PACKETS);
                  pkt.volume = EVENT_VOLUME;
                  pkt.duration = dur_samples[DUR_W-1:0];
                  packets_done++;
                  if (packets_done >= PACKETS_PER_DIGIT) begin
                     digit_active = 1'b0;
                     // queue only empties once every digit has gone out
                     if (rd_idx >= q_len) begin
                        q_len = 0;
                        rd_idx = 0;
                     end
                  end
               end else begin
                  pkt.kind = KIND_AUDIO;
                  pkt.marker = !audio_started;
                  pkt.payload_type = PT_PCMU;
                  pkt.timestamp = next_ts;
                  audio_started = 1'b1;
               end
               next_seq = next_seq + 1'b1;
               next_ts = next_ts + FRAME_SAMPLES;
               expected_packets.push_back(pkt);
            end
         end
         OP_PUSH: begin
            if (q_len >= QUEUE_DEPTH) begin
               pkt.kind = KIND_REJECT;
               expected_packets.push_back(pkt);
            end else begin
               digit_store[q_len] = digit;
               q_len++;
            end
         end
         OP_RESTART: begin
            next_seq = cfg_init_seq;
            next_ts = cfg_init_ts;
            q_len = 0;
            rd_idx = 0;
            digit_active = 1'b0;
            packets_done = 0;
            audio_started = 1'b0;
         end
         default: ;
      endcase
   endtask

   function automatic void check_field(input string label, input longint unsigned want,
                                       input longint unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: pops pending items, inserts random idle bursts
   // ------------------------------------------------------------------
   int  req_gap = 0;
   bit  req_quiet = 1'b0;

   always @(posedge clock) begin
      request_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && !req_quiet && $urandom_range(0, 4) == 0) begin
               // idle burst: this cycle plus req_gap further ones
               req_gap = $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.op;
               req_tdata <= nxt.digit;
               // switch now and then between bursty and back-to-back stretches
               if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: checks packets, drives rsp_tready with stalls
   // ------------------------------------------------------------------
   int  rsp_gap = 0;
   int  holdoff_left = 0;
   bit  rsp_quiet = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_packets.size() == 0) begin
               $display("%0t: unexpected packet, expected none, actual kind %0d tdata 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_packets.pop_front();
               check_field("packet_kind", want.kind, rsp_tuser);
               check_field("marker", want.marker, rsp_tdata[0]);
               check_field("payload_type", want.payload_type, rsp_tdata[7:1]);
               check_field("sequence_number", want.sequence_number, rsp_tdata[23:8]);
               check_field("timestamp", want.timestamp, rsp_tdata[55:24]);
               check_field("dtmf_event", want.dtmf_event, rsp_tdata[63:56]);
               check_field("end_flag", want.end_flag, rsp_tdata[64]);
               check_field("volume", want.volume, rsp_tdata[70:65]);
               check_field("duration", want.duration, rsp_tdata[81:71]);
               check_field("tdata padding", 0, rsp_tdata[87:82]);
            end
         end
         if (holdoff_served != holdoff_requests) begin
            // long stall: the block fills up and must push back on requests
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && !rsp_quiet && $urandom_range(0, 4) == 0) begin
            rsp_gap = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0) rsp_quiet = !rsp_quiet;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: no handshake for too long while work is outstanding
   // ------------------------------------------------------------------
   int stalled_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_requests.size() == 0 && !req_tvalid && expected_packets.size() == 0)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_request(input logic [1:0] op, input logic [7:0] digit);
      request_item_type it;
      it.op = op;
      it.digit = digit;
      pending_requests.push_back(it);
      if (op != OP_UNUSED) requests_queued++;
   endtask

   // Block until every request is taken and every packet seen, then let the
   // pipeline settle so pushes and restarts in flight have landed.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_packets.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all five registers back to back; only called with the block idle
   task automatic program_registers(input logic peer, input logic [31:0] ssrc,
                                    input logic [PT_W-1:0] ev_pt,
                                    input logic [SEQ_W-1:0] init_seq,
                                    input logic [TS_W-1:0] init_ts);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [31:0]          val [5];
      idx[0] = CSR_PEER_KNOWN;    val[0] = {31'd0, peer};
      idx[1] = CSR_SYNC_SOURCE;   val[1] = ssrc;
      idx[2] = CSR_EVENT_PT;      val[2] = {25'd0, ev_pt};
      idx[3] = CSR_INIT_SEQUENCE; val[3] = {16'd0, init_seq};
      idx[4] = CSR_INIT_TSTAMP;   val[4] = init_ts;
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_peer_known = peer;
      cfg_ssrc = ssrc;
      cfg_event_pt = ev_pt;
      cfg_init_seq = init_seq;
      cfg_init_ts = init_ts;
   endtask

   // Random traffic: digit runs and other patterns, with random content
   task automatic add_random_requests(input int target);
      int goal, pick, n;
      goal = requests_queued + target;
      while (requests_queued < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // digits followed by enough ticks to send them all
            n = $urandom_range(1, 4);
            repeat (n) queue_request(OP_PUSH, 8'($urandom));
            repeat (n * PACKETS_PER_DIGIT + $urandom_range(0, 3))
               queue_request(OP_TICK, 8'($urandom));
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 10)) queue_request(OP_TICK, 8'($urandom));
         end else if (pick < 70) begin
            // overrun the queue: late pushes are rejected
            repeat ($urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 4))
               queue_request(OP_PUSH, 8'($urandom));
            repeat ($urandom_range(0, 40)) queue_request(OP_TICK, 8'($urandom));
         end else if (pick < 80) begin
            // restart in the middle of a digit
            repeat ($urandom_range(1, 2)) queue_request(OP_PUSH, 8'($urandom));
            repeat ($urandom_range(0, 10)) queue_request(OP_TICK, 8'($urandom));
            queue_request(OP_RESTART, 8'($urandom));
         end else if (pick < 90) begin
            // refill while digits are still pending: sent slots still count
            n = $urandom_range(4, 10);
            repeat (n) queue_request(OP_PUSH, 8'($urandom));
            repeat ($urandom_range(1, 2 * PACKETS_PER_DIGIT))
               queue_request(OP_TICK, 8'($urandom));
            repeat (n) queue_request(OP_PUSH, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6))
               queue_request(2'($urandom_range(0, 3)), 8'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Peer unknown after reset: ticks are silent, unused opcode ignored
      queue_request(OP_TICK, 8'h00);
      queue_request(OP_UNUSED, 8'hAA);
      queue_request(OP_RESTART, 8'h55);
      wait_idle();

      // Extremes: sequence and timestamp both wrap within the first packets
      program_registers(1'b1, 32'hFFFF_FFFF, 7'd127, 16'hFFFF, 32'hFFFF_FF60);
      queue_request(OP_RESTART, 8'h00);
      queue_request(OP_TICK, 8'h00);     // first audio packet, marker set
      queue_request(OP_TICK, 8'hFF);     // audio, no marker, sequence wraps
      queue_request(OP_PUSH, 8'hFF);
      queue_request(OP_PUSH, 8'h00);
      repeat (2 * PACKETS_PER_DIGIT) queue_request(OP_TICK, 8'h3C);
      queue_request(OP_TICK, 8'h00);     // back to audio, no marker
      queue_request(OP_RESTART, 8'hFF);
      queue_request(OP_TICK, 8'h00);     // audio marker again after restart
      wait_idle();

      // Random config; a long receiver stall while requests keep coming
      program_registers(1'b1, $urandom, PT_W'($urandom), SEQ_W'($urandom), $urandom);
      queue_request(OP_RESTART, 8'h00);
      add_random_requests(150);
      holdoff_requests++;
      wait_idle();

      // All-zero extremes
      program_registers(1'b1, 32'd0, 7'd0, 16'd0, 32'd0);
      queue_request(OP_RESTART, 8'h00);
      add_random_requests(100);
      wait_idle();

      // Peer lost: ticks silent, only rejected pushes give packets
      program_registers(1'b0, $urandom, PT_W'($urandom), SEQ_W'($urandom), $urandom);
      add_random_requests(40);
      wait_idle();

      // Last part: near-wrap start values and no idling on either side
      program_registers(1'b1, 32'hFFFF_FFFF, 7'd127, 16'hFFF0, 32'hFFFF_F000);
      calm = 1'b1;
      queue_request(OP_RESTART, 8'h00);
      add_random_requests(200);
      wait_idle();

      if (mismatch_count == 0 && expected_packets.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rtpds_pkg.sv
rtl/core/rtpds_ram.sv
rtl/core/rtp_dtmf_packet_sequencer.sv
tb/tb_rtp_dtmf_packet_sequencer.sv
